// File: sv/clad_pkg.sv
`default_nettype none

package clad_pkg;

   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] found_value;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                      compare;
      logic                      update;
      logic                      do_append;
      logic                      do_delete;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/clad_cell.sv
`default_nettype none

module clad_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire                           clock,
   input  clad_pkg::cell_ctrl_type       ctrl,
   input  wire [CNT_W-1:0]               count,
   input  wire signed [31:0]             next_entry,
   input  wire                           hit_below_in,
   output logic                          hit_below_out,
   output logic signed [31:0]            entry
);
   import clad_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      hit_ff, hit_in;
   logic                      valid;
   logic                      shift;

   assign valid = (MY_INDEX < count);

   always_comb begin
      hit_in = hit_ff;
      if (ctrl.compare) begin
         hit_in = valid && (entry_ff == ctrl.value);
      end
   end

   // a match here or in any lower cell pulls the upper neighbor down
   assign hit_below_out = hit_below_in | hit_ff;
   assign shift = ctrl.update & ctrl.do_delete & hit_below_out;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.update && ctrl.do_append && (count == MY_INDEX)) begin
         entry_in = ctrl.value;
      end else if (shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: sv/compacting_list_add_delete_find_core.sv
`default_nettype none
// An accepted command is registered, then walks the compare and update states;
// rsp_valid and rsp are registered out of the update state. busy stays high
// through the compare cycle (every cell matches its entry in parallel) and the
// update cycle (first-match chain, neighbor shift, append write), so a new command waits for the last.
// Reset clears the count and the sequencer; entry contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module compacting_list_add_delete_find_core #(
   parameter int CAPACITY = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  clad_pkg::req_type  req,
   output logic               rsp_valid,
   output clad_pkg::rsp_type  rsp
);
   import clad_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_UPD  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   cell_ctrl_type             ctrl;
   logic [CAPACITY:0]         hit_chain;
   logic signed [VALUE_W-1:0] entry_bus [CAPACITY];
   logic                      any_hit;
   logic [CNT_W+COUNT_W-1:0]  count_ext;

   assign busy = (state_ff != S_IDLE);

   assign ctrl.compare   = (state_ff == S_CMP);
   assign ctrl.update    = (state_ff == S_UPD);
   assign ctrl.do_append = (cmd_ff == CMD_APPEND);
   assign ctrl.do_delete = (cmd_ff == CMD_DELETE);
   assign ctrl.value     = value_ff;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] next_entry;
      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = entry_bus[i+1];
      end
      clad_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .count         (count_ff),
         .next_entry    (next_entry),
         .hit_below_in  (hit_chain[i]),
         .hit_below_out (hit_chain[i+1]),
         .entry         (entry_bus[i])
      );
   end

   assign any_hit = hit_chain[CAPACITY];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req.command;
               value_in = req.value;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            rsp_in.status      = ST_NOT_FOUND;
            rsp_in.found_value = '0;
            case (cmd_ff)
               CMD_APPEND: begin
                  if (count_ff >= CAP_CNT) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status = ST_OK;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               CMD_DELETE: begin
                  if (any_hit) begin
                     rsp_in.status = ST_OK;
                     count_in      = count_ff - CNT_W'(1);
                  end
               end
               CMD_FIND: begin
                  if (any_hit) begin
                     rsp_in.status      = ST_OK;
                     rsp_in.found_value = value_ff;
                  end
               end
               default: begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            endcase
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      count_ext          = (CNT_W+COUNT_W)'(count_in);
      rsp_in.entry_count = count_ext[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_UPD))
      else $error("result without an update cycle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_CMP))
      else $error("accepted command did not start");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("count above capacity");

   a_count_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_UPD) |=> $stable(count_ff))
      else $error("count changed outside update");

   a_no_hit_on_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && count_ff == '0) |-> !any_hit)
      else $error("match reported on an empty list");

endmodule

`default_nettype wire

// File: verif/list_checker.sv
`default_nettype none

module list_checker #(
   parameter int CAPACITY = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                busy,
   input  clad_pkg::req_type  req,
   input  wire                rsp_valid,
   input  clad_pkg::rsp_type  rsp,
   output int                 fail_count,
   output int                 pending,
   output int                 results_seen,
   output int                 full_refusals,
   output int                 lookup_misses
);
   import clad_pkg::*;

   // shadow copy of the valid entries, index 0 first
   logic signed [VALUE_W-1:0] shadow_list[$];
   rsp_type                   due_q[$];
   int                        errs = 0;
   int                        n_seen = 0;
   int                        n_full = 0;
   int                        n_miss = 0;

   task automatic report_error(input string msg);
      errs++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic rsp_type apply_command(input req_type r);
      rsp_type o;
      int      hit;
      o.status      = ST_NOT_FOUND;
      o.found_value = '0;
      hit           = -1;
      foreach (shadow_list[i]) begin
         if (hit < 0 && shadow_list[i] == r.value) begin
            hit = i;
         end
      end
      case (r.command)
         CMD_APPEND: begin
            if (shadow_list.size() >= CAPACITY) begin
               o.status = ST_FULL;
               n_full++;
            end else begin
               shadow_list.push_back(r.value);
               o.status = ST_OK;
            end
         end
         CMD_DELETE: begin
            if (hit >= 0) begin
               shadow_list.delete(hit);
               o.status = ST_OK;
            end else begin
               n_miss++;
            end
         end
         CMD_FIND: begin
            if (hit >= 0) begin
               o.found_value = shadow_list[hit];
               o.status      = ST_OK;
            end else begin
               n_miss++;
            end
         end
         default: begin
            // unused code: no change, reads as not found
         end
      endcase
      o.entry_count = COUNT_W'(shadow_list.size());
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_q.size() == 0) begin
               report_error($sformatf("result with no command outstanding: status %0d count %0d",
                                      rsp.status, rsp.entry_count));
            end else begin
               want = due_q.pop_front();
               n_seen++;
               if (rsp.status !== want.status) begin
                  report_error($sformatf("status %0d, expected %0d", rsp.status, want.status));
               end
               if (rsp.found_value !== want.found_value) begin
                  report_error($sformatf("found_value %0d, expected %0d",
                                         rsp.found_value, want.found_value));
               end
               if (rsp.entry_count !== want.entry_count) begin
                  report_error($sformatf("entry_count %0d, expected %0d",
                                         rsp.entry_count, want.entry_count));
               end
            end
         end
         if (start && !busy) begin
            due_q.push_back(apply_command(req));
         end
      end
      fail_count    <= errs;
      pending       <= due_q.size();
      results_seen  <= n_seen;
      full_refusals <= n_full;
      lookup_misses <= n_miss;
   end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
   import clad_pkg::*;

   localparam int CAPACITY = 16;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int MIX_FILL  = 0;
   localparam int MIX_DRAIN = 1;
   localparam int MIX_EVEN  = 2;
   localparam int N_RANDOM  = 1000;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp;

   int fail_count;
   int pending;
   int results_seen;
   int full_refusals;
   int lookup_misses;
   int sent = 0;

   compacting_list_add_delete_find_core #(.CAPACITY(CAPACITY)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req           (req),
      .rsp_valid     (rsp_valid),
      .rsp           (rsp),
      .fail_count    (fail_count),
      .pending       (pending),
      .results_seen  (results_seen),
      .full_refusals (full_refusals),
      .lookup_misses (lookup_misses)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 400000);
      $display("Timed out with %0d results still outstanding", pending);
      $display("DONE: errors detected");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer, or later for a gap or a drain.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] val,
                            input int gap, input bit drain);
      start <= 1'b1;
      req   <= '{command: cmd, value: val};
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
      if (gap > 0 || drain) begin
         start <= 1'b0;
         if (drain) begin
            do @(posedge clock); while (pending != 0);
            @(negedge clock);
         end
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      logic signed [VALUE_W-1:0] pool[8];
      logic signed [VALUE_W-1:0] val;
      logic [CMD_W-1:0]          cmd;
      int                        mix;
      int                        roll;
      int                        lim_a;
      int                        lim_d;
      int                        lim_f;
      int                        gap;
      bit                        no_gaps;
      int                        waited;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, extremes, duplicates, misses, unused code
      send_item(CMD_FIND,   32'sd0,    0, 0);
      send_item(CMD_DELETE, 32'sd0,    0, 0);
      send_item(CMD_UNUSED, 32'sd0,    1, 0);
      send_item(CMD_APPEND, VAL_MIN,   0, 0);
      send_item(CMD_APPEND, VAL_MAX,   0, 0);
      send_item(CMD_APPEND, 32'sd0,    2, 0);
      send_item(CMD_APPEND, -32'sd1,   0, 0);
      send_item(CMD_APPEND, VAL_MIN,   0, 0);
      send_item(CMD_FIND,   VAL_MIN,   0, 0);
      send_item(CMD_FIND,   VAL_MAX,   1, 0);
      send_item(CMD_FIND,   32'sd0,    0, 0);
      send_item(CMD_FIND,   32'sd123,  0, 0);
      send_item(CMD_UNUSED, -32'sd1,   0, 0);
      send_item(CMD_DELETE, VAL_MIN,   0, 0);
      send_item(CMD_FIND,   VAL_MIN,   3, 0);
      send_item(CMD_DELETE, 32'sd55,   0, 0);
      send_item(CMD_DELETE, VAL_MAX,   0, 0);
      send_item(CMD_DELETE, -32'sd1,   0, 0);
      send_item(CMD_DELETE, 32'sd0,    0, 0);
      send_item(CMD_DELETE, VAL_MIN,   0, 0);
      send_item(CMD_FIND,   VAL_MIN,   0, 1);

      // small value pool so deletes and finds hit; extremes included
      pool[0] = VAL_MIN;
      pool[1] = VAL_MAX;
      pool[2] = 32'sd0;
      pool[3] = -32'sd1;
      for (int i = 4; i < 8; i++) begin
         pool[i] = $urandom;
      end

      mix     = MIX_FILL;
      no_gaps = 1'b0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 120 == 0) begin
            mix     = (n == 0) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_EVEN);
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         case (mix)
            MIX_FILL: begin
               lim_a = 75; lim_d = 85; lim_f = 95;
            end
            MIX_DRAIN: begin
               lim_a = 15; lim_d = 75; lim_f = 95;
            end
            default: begin
               lim_a = 40; lim_d = 70; lim_f = 95;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < lim_a) cmd = CMD_APPEND;
         else if (roll < lim_d) cmd = CMD_DELETE;
         else if (roll < lim_f) cmd = CMD_FIND;
         else cmd = CMD_UNUSED;

         val = ($urandom_range(0, 99) < 65) ? pool[$urandom_range(0, 7)] : $urandom;

         roll = $urandom_range(0, 99);
         if (no_gaps || roll < 60) gap = 0;
         else if (roll < 90) gap = $urandom_range(1, 3);
         else if (roll < 97) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 60);

         send_item(cmd, val, gap, (n == N_RANDOM / 2) || ($urandom_range(0, 199) == 0));
      end

      start <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < 2000);
      repeat (6) @(posedge clock);

      if (pending != 0) begin
         $display("%0d expected results never arrived", pending);
      end
      $display("Run covered %0d commands with %0d results checked against the shadow list,",
               sent, results_seen);
      $display("including %0d appends refused on a full list and %0d lookups with no match.",
               full_refusals, lookup_misses);
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
